@@ sv/med_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register indexes of the multiband energy detector.
// Depends on nothing; every other file of the block uses it by scoped names.
package med_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_STREAMS  = 4;
    localparam int MAX_BINS_DEF = 4096;

    localparam int CNT_W      = 13;             // bins_per_stream and fft_size
    localparam int SC_W       = 3;              // stream_count
    localparam int STREAM_W   = 2;              // stream_index
    localparam int WORD_W     = 32;             // threshold, inverse variance, results
    localparam int E_W        = 2 * SAMPLE_WIDTH;
    localparam int SUM_W      = 44;
    localparam int DVD_W      = SUM_W;
    localparam int DVS_W      = 2 * CNT_W;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BINS_PER_STREAM  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_COUNT     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FFT_SIZE         = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_THRESHOLD = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_NOISE_VAR_0  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_NOISE_VAR_1  = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_NOISE_VAR_2  = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_NOISE_VAR_3  = CFG_IDX_W'(7);

    localparam logic [CNT_W-1:0]  RST_BINS_PER_STREAM  = CNT_W'(1024);
    localparam logic [SC_W-1:0]   RST_STREAM_COUNT     = SC_W'(1);
    localparam logic [CNT_W-1:0]  RST_FFT_SIZE         = CNT_W'(4096);
    localparam logic [WORD_W-1:0] RST_DETECT_THRESHOLD = WORD_W'(0);
    localparam logic [WORD_W-1:0] RST_INV_NOISE_VAR    = WORD_W'(65536);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] i_sample;
        logic signed [SAMPLE_WIDTH-1:0] q_sample;
    } in_word_t;

    typedef struct packed {
        logic [STREAM_W-1:0] stream_index;
        logic [WORD_W-1:0]   normalized_energy;
        logic [WORD_W-1:0]   noise_ratio;
        logic                detected;
        logic                config_error;
        logic                last_result;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_RUN,
        ST_TRK_GO,
        ST_TRK_WAIT,
        ST_DRAIN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MUL,
        ST_SAT,
        ST_ERR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                accept;
        logic                trk_start;
        logic                trk_load;
        logic                frm_start;
        logic                ne_load;
        logic                mul_load;
        logic                out_load;
        logic                out_err;
        logic                clear_sums;
        logic [STREAM_W-1:0] stream;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic cfg_ok;
        logic div_done;
        logic out_taken;
        logic out_last;
    } stat_t;

endpackage

@@ sv/med_divider.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by window tracking and
// frame-end normalization. Depends on med_pkg for operand widths.
module med_divider (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [med_pkg::DVD_W-1:0] dividend,
    input  logic [med_pkg::DVS_W-1:0] divisor,
    output logic                      done,
    output logic [med_pkg::DVD_W-1:0] quotient,
    output logic [med_pkg::DVS_W-1:0] remainder
);

    localparam int DVD_W = med_pkg::DVD_W;
    localparam int DVS_W = med_pkg::DVS_W;
    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    always_comb begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // shift in one dividend bit, subtract when the divisor fits
            quo_next = {quo_reg[DVD_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ sv/med_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: configuration registers, bin position and window tracking, energy
// accumulators, divider, scaling multiplier and output register. Uses med_pkg, med_divider.
module med_datapath #(
    parameter int MAX_BINS = med_pkg::MAX_BINS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  med_pkg::in_word_t              s_data,
    input  logic                           cfg_we,
    input  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [med_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  med_pkg::cmd_t                  cmd,
    output med_pkg::stat_t                 stat,
    output logic                           m_valid,
    input  logic                           m_ready,
    output med_pkg::out_word_t             m_data
);

    localparam int POS_W    = $clog2(MAX_BINS);
    localparam int CNT_W    = med_pkg::CNT_W;
    localparam int SC_W     = med_pkg::SC_W;
    localparam int WORD_W   = med_pkg::WORD_W;
    localparam int E_W      = med_pkg::E_W;
    localparam int SUM_W    = med_pkg::SUM_W;
    localparam int DVD_W    = med_pkg::DVD_W;
    localparam int DVS_W    = med_pkg::DVS_W;
    localparam int PROD_W   = med_pkg::PROD_W;
    localparam int STREAM_W = med_pkg::STREAM_W;
    localparam int NUM_ACC  = med_pkg::MAX_STREAMS;
    localparam int TOT_W    = CNT_W + SC_W;
    localparam int CMP_W    = (POS_W + 1 > CNT_W + 1) ? POS_W + 1 : CNT_W + 1;

    // configuration
    logic [CNT_W-1:0]  bps_reg, fft_reg;
    logic [SC_W-1:0]   sc_reg;
    logic [WORD_W-1:0] thr_reg;
    logic [WORD_W-1:0] inv_reg [NUM_ACC];

    // frame state
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [STREAM_W-1:0] trk_k_reg, trk_k_next;
    logic [CNT_W-1:0]    trk_off_reg, trk_off_next;
    logic                stg_en_reg, stg_en_next;
    logic [STREAM_W-1:0] stg_k_reg, stg_k_next;
    logic [E_W-1:0]      stg_sqi_reg, stg_sqq_reg;
    logic [SUM_W-1:0]    sum_reg [NUM_ACC];
    logic                m_valid_reg, m_valid_next;

    // result payload
    logic [WORD_W-1:0]      ne_reg;
    logic [PROD_W-1:0]      prod_reg;
    med_pkg::out_word_t     out_reg;

    // window and frame decode
    logic [TOT_W-1:0] total;
    logic [CNT_W-1:0] half, start_pos;
    logic [CMP_W-1:0] pos_c, start_c, end_c, len_c;
    logic             cfg_ok, in_win, frame_end, at_start, acc_bin;
    logic [STREAM_W-1:0] cur_k;
    logic [CNT_W-1:0]    cur_off;

    logic signed [E_W-1:0] sqi, sqq;
    logic [SUM_W-1:0]      bin_energy;

    logic             div_start, div_done;
    logic [DVD_W-1:0] div_dvd, div_quo;
    logic [DVS_W-1:0] div_dvs, div_rem;

    logic [WORD_W-1:0] ratio;
    logic              stream_last;

    always_comb begin
        total   = TOT_W'(bps_reg) * TOT_W'(sc_reg);
        cfg_ok  = (bps_reg != '0) && (CMP_W'(bps_reg) <= CMP_W'(MAX_BINS)) &&
                  (sc_reg != '0) && (sc_reg <= SC_W'(med_pkg::MAX_STREAMS)) &&
                  (fft_reg != '0) && (CMP_W'(fft_reg) <= CMP_W'(MAX_BINS)) &&
                  (total <= TOT_W'(fft_reg));
        half      = CNT_W'((TOT_W'(fft_reg) - total) >> 1);
        start_pos = (half != '0) ? half - CNT_W'(1) : '0;
        pos_c     = CMP_W'(pos_reg);
        start_c   = CMP_W'(start_pos);
        end_c     = start_c + CMP_W'(total);
        in_win    = (pos_c >= start_c) && (pos_c < end_c);
        if (fft_reg == '0) begin
            len_c = CMP_W'(1);
        end else if (CMP_W'(fft_reg) > CMP_W'(MAX_BINS)) begin
            len_c = CMP_W'(MAX_BINS);
        end else begin
            len_c = CMP_W'(fft_reg);
        end
        frame_end = (pos_c + CMP_W'(1)) >= len_c;
        at_start  = pos_c == start_c;
        acc_bin   = cfg_ok && in_win;
        cur_k     = at_start ? '0 : trk_k_reg;
        cur_off   = at_start ? '0 : trk_off_reg;
    end

    always_comb begin
        sqi        = s_data.i_sample * s_data.i_sample;
        sqq        = s_data.q_sample * s_data.q_sample;
        bin_energy = SUM_W'(stg_sqi_reg) + SUM_W'(stg_sqq_reg);
    end

    // position, group tracking and accumulate stage
    always_comb begin
        pos_next     = pos_reg;
        trk_k_next   = trk_k_reg;
        trk_off_next = trk_off_reg;
        stg_en_next  = 1'b0;
        stg_k_next   = stg_k_reg;
        if (cmd.accept) begin
            pos_next    = frame_end ? '0 : pos_reg + POS_W'(1);
            stg_en_next = acc_bin;
            stg_k_next  = cur_k;
            if (acc_bin) begin
                if (cur_off + CNT_W'(1) == bps_reg) begin
                    trk_k_next   = cur_k + STREAM_W'(1);
                    trk_off_next = '0;
                end else begin
                    trk_k_next   = cur_k;
                    trk_off_next = cur_off + CNT_W'(1);
                end
            end
        end else if (cmd.trk_load) begin
            trk_k_next   = div_quo[STREAM_W-1:0];
            trk_off_next = div_rem[CNT_W-1:0];
        end
    end

    always_comb begin
        div_start = cmd.trk_start || cmd.frm_start;
        if (cmd.frm_start) begin
            div_dvd = sum_reg[cmd.stream];
            div_dvs = DVS_W'(fft_reg) * DVS_W'(bps_reg);
        end else begin
            div_dvd = DVD_W'(pos_c - start_c);
            div_dvs = DVS_W'(bps_reg);
        end
    end

    med_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        ratio        = (prod_reg[PROD_W-1:48] != '0) ? '1 : prod_reg[47:16];
        stream_last  = (SC_W'(cmd.stream) + SC_W'(1)) == sc_reg;
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg     <= med_pkg::RST_BINS_PER_STREAM;
            sc_reg      <= med_pkg::RST_STREAM_COUNT;
            fft_reg     <= med_pkg::RST_FFT_SIZE;
            thr_reg     <= med_pkg::RST_DETECT_THRESHOLD;
            for (int n = 0; n < NUM_ACC; n++) begin
                inv_reg[n] <= med_pkg::RST_INV_NOISE_VAR;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                med_pkg::CFG_BINS_PER_STREAM:  bps_reg    <= cfg_wdata[CNT_W-1:0];
                med_pkg::CFG_STREAM_COUNT:     sc_reg     <= cfg_wdata[SC_W-1:0];
                med_pkg::CFG_FFT_SIZE:         fft_reg    <= cfg_wdata[CNT_W-1:0];
                med_pkg::CFG_DETECT_THRESHOLD: thr_reg    <= cfg_wdata[WORD_W-1:0];
                med_pkg::CFG_INV_NOISE_VAR_0:  inv_reg[0] <= cfg_wdata[WORD_W-1:0];
                med_pkg::CFG_INV_NOISE_VAR_1:  inv_reg[1] <= cfg_wdata[WORD_W-1:0];
                med_pkg::CFG_INV_NOISE_VAR_2:  inv_reg[2] <= cfg_wdata[WORD_W-1:0];
                med_pkg::CFG_INV_NOISE_VAR_3:  inv_reg[3] <= cfg_wdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            trk_k_reg   <= '0;
            trk_off_reg <= '0;
            stg_en_reg  <= 1'b0;
            stg_k_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int n = 0; n < NUM_ACC; n++) begin
                sum_reg[n] <= '0;
            end
        end else begin
            pos_reg     <= pos_next;
            trk_k_reg   <= trk_k_next;
            trk_off_reg <= trk_off_next;
            stg_en_reg  <= stg_en_next;
            stg_k_reg   <= stg_k_next;
            m_valid_reg <= m_valid_next;
            if (cmd.clear_sums) begin
                for (int n = 0; n < NUM_ACC; n++) begin
                    sum_reg[n] <= '0;
                end
            end else if (stg_en_reg) begin
                sum_reg[stg_k_reg] <= sum_reg[stg_k_reg] + bin_energy;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            stg_sqi_reg <= $unsigned(sqi);
            stg_sqq_reg <= $unsigned(sqq);
        end
        if (cmd.ne_load) begin
            ne_reg <= div_quo[WORD_W-1:0];
        end
        if (cmd.mul_load) begin
            prod_reg <= PROD_W'(ne_reg) * PROD_W'(inv_reg[cmd.stream]);
        end
        if (cmd.out_load) begin
            if (cmd.out_err) begin
                out_reg              <= '0;
                out_reg.config_error <= 1'b1;
                out_reg.last_result  <= 1'b1;
            end else begin
                out_reg.stream_index      <= cmd.stream;
                out_reg.normalized_energy <= ne_reg;
                out_reg.noise_ratio       <= ratio;
                out_reg.detected          <= ratio > thr_reg;
                out_reg.config_error      <= 1'b0;
                out_reg.last_result       <= stream_last;
            end
        end
    end

    assign stat.frame_end = frame_end;
    assign stat.cfg_ok    = cfg_ok;
    assign stat.div_done  = div_done;
    assign stat.out_taken = m_valid_reg && m_ready;
    assign stat.out_last  = out_reg.last_result;
    assign m_valid        = m_valid_reg;
    assign m_data         = out_reg;

endmodule

@@ sv/med_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: bin intake, window re-sync after register writes,
// and the per-stream divide, scale and output sequence. Uses med_pkg.
module med_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           cfg_we,
    input  med_pkg::stat_t stat,
    output med_pkg::cmd_t  cmd
);

    localparam int STREAM_W = med_pkg::STREAM_W;

    med_pkg::state_t     state_reg, state_next;
    logic                dirty_reg, dirty_next;
    logic [STREAM_W-1:0] stream_reg, stream_next;
    logic                ready_int;
    logic                accept;

    always_comb begin
        ready_int = (state_reg == med_pkg::ST_RUN) && !dirty_reg;
        accept    = s_valid && ready_int;
    end

    // next state
    always_comb begin
        state_next  = state_reg;
        stream_next = stream_reg;
        dirty_next  = dirty_reg;
        case (state_reg)
            med_pkg::ST_RUN: begin
                if (accept && stat.frame_end) begin
                    stream_next = '0;
                    state_next  = stat.cfg_ok ? med_pkg::ST_DRAIN : med_pkg::ST_ERR;
                end else if (dirty_reg) begin
                    state_next = med_pkg::ST_TRK_GO;
                end
            end
            med_pkg::ST_TRK_GO: begin
                dirty_next = 1'b0;
                state_next = med_pkg::ST_TRK_WAIT;
            end
            med_pkg::ST_TRK_WAIT: begin
                if (stat.div_done) begin
                    state_next = med_pkg::ST_RUN;
                end
            end
            med_pkg::ST_DRAIN:    state_next = med_pkg::ST_DIV_GO;
            med_pkg::ST_DIV_GO:   state_next = med_pkg::ST_DIV_WAIT;
            med_pkg::ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    state_next = med_pkg::ST_MUL;
                end
            end
            med_pkg::ST_MUL: state_next = med_pkg::ST_SAT;
            med_pkg::ST_SAT: state_next = med_pkg::ST_OUT;
            med_pkg::ST_ERR: state_next = med_pkg::ST_OUT;
            med_pkg::ST_OUT: begin
                if (stat.out_taken) begin
                    if (stat.out_last) begin
                        state_next = med_pkg::ST_RUN;
                    end else begin
                        stream_next = stream_reg + STREAM_W'(1);
                        state_next  = med_pkg::ST_DIV_GO;
                    end
                end
            end
            default: state_next = med_pkg::ST_RUN;
        endcase
        if (cfg_we) begin
            dirty_next = 1'b1;
        end
    end

    // outputs
    always_comb begin
        cmd            = '0;
        cmd.stream     = stream_reg;
        cmd.accept     = accept;
        case (state_reg)
            med_pkg::ST_TRK_GO:   cmd.trk_start = 1'b1;
            med_pkg::ST_TRK_WAIT: cmd.trk_load  = stat.div_done;
            med_pkg::ST_DIV_GO:   cmd.frm_start = 1'b1;
            med_pkg::ST_DIV_WAIT: cmd.ne_load   = stat.div_done;
            med_pkg::ST_MUL:      cmd.mul_load  = 1'b1;
            med_pkg::ST_SAT:      cmd.out_load  = 1'b1;
            med_pkg::ST_ERR: begin
                cmd.out_load = 1'b1;
                cmd.out_err  = 1'b1;
            end
            med_pkg::ST_OUT:      cmd.clear_sums = stat.out_taken && stat.out_last;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= med_pkg::ST_RUN;
            dirty_reg  <= 1'b0;
            stream_reg <= '0;
        end else begin
            state_reg  <= state_next;
            dirty_reg  <= dirty_next;
            stream_reg <= stream_next;
        end
    end

    assign s_ready = ready_int;

endmodule

@@ sv/multiband_energy_detector_top.sv @@
`timescale 1ns / 1ps
// Multiband energy detector, top level: joins the controller and the datapath.
// Depends on med_pkg, med_ctrl, med_datapath (and med_divider below it).
//   s_valid/s_ready/s_data carry one FFT bin word (I and Q) per handshake.
//   Bins count into frames of fft_size words; a centered window of
//   stream_count groups of bins_per_stream bins is accumulated per frame.
//   m_valid/m_ready/m_data carry one result word per stream at frame end,
//   or one config_error word if a setting is bad or the window won't fit.
//   cfg_we/cfg_index/cfg_wdata write one register per cycle, no wait.
// Inside a frame one bin word is taken every cycle unless a register write
//   has dropped s_ready. After the last bin, s_ready drops: a drain step,
//   then per stream a divider start, the divide of 44 quotient bits, a
//   multiply and a scale step that loads the result word. An error frame
//   loads its word through the error state instead.
// Each register write drops s_ready for a window re-sync through
//   the same divider.
// Reset (aresetn low, synchronous): registers return to defaults, frame
//   position and accumulators clear; no clearing pass is needed.
// Stall: a result word holds in the output register until taken; no new
//   bin word is taken until the last result of the frame is gone.
module multiband_energy_detector_top #(
    parameter int MAX_BINS = med_pkg::MAX_BINS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  med_pkg::in_word_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output med_pkg::out_word_t             m_data,
    input  logic                           cfg_we,
    input  logic [med_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [med_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    med_pkg::cmd_t  cmd;
    med_pkg::stat_t stat;

    // sequencing: intake, re-sync after writes, per-stream result loop
    med_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cfg_we  (cfg_we),
        .stat    (stat),
        .cmd     (cmd)
    );

    // registers, accumulators, divider, scaling and output word
    med_datapath #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
